// File: rtl/aqi_pkg.sv
package aqi_pkg;

   localparam int NumPoll   = 5;
   localparam int TableRows = 6;
   localparam int SumW      = 24;
   localparam int CntW      = 8;
   localparam int IdxW      = 13;
   localparam int AvgW      = SumW + 4;
   localparam int DivSteps  = AvgW;
   localparam int DefBands  = 6;
   localparam logic [IdxW-1:0] IndexMax = 13'd8191;

   typedef struct packed {
      logic [SumW-1:0] tvoc;
      logic [SumW-1:0] pm10;
      logic [SumW-1:0] pm4;
      logic [SumW-1:0] pm25;
      logic [SumW-1:0] pm1;
   } sums_type;

   typedef struct packed {
      logic [IdxW-1:0] tvoc;
      logic [IdxW-1:0] pm10;
      logic [IdxW-1:0] pm4;
      logic [IdxW-1:0] pm25;
      logic [IdxW-1:0] pm1;
   } subs_type;

   // one breakpoint row, concentrations in 0.1 units
   typedef struct packed {
      logic [16:0] cp_lo;
      logic [16:0] cp_hi;
      logic [8:0]  ip_lo;
      logic [8:0]  ip_hi;
   } band_type;

   function automatic band_type bp_row(input logic [2:0] p, input logic [2:0] r);
      band_type b;
      b = '0;
      unique case ({p, r})
         {3'd0,3'd0}: b = '{17'd0,     17'd80,     9'd0,   9'd50};
         {3'd0,3'd1}: b = '{17'd81,    17'd254,    9'd51,  9'd100};
         {3'd0,3'd2}: b = '{17'd255,   17'd354,    9'd101, 9'd150};
         {3'd0,3'd3}: b = '{17'd355,   17'd504,    9'd151, 9'd200};
         {3'd0,3'd4}: b = '{17'd505,   17'd754,    9'd201, 9'd300};
         {3'd0,3'd5}: b = '{17'd755,   17'd5004,   9'd301, 9'd500};
         {3'd1,3'd0}: b = '{17'd0,     17'd120,    9'd0,   9'd50};
         {3'd1,3'd1}: b = '{17'd121,   17'd354,    9'd51,  9'd100};
         {3'd1,3'd2}: b = '{17'd355,   17'd554,    9'd101, 9'd150};
         {3'd1,3'd3}: b = '{17'd555,   17'd1504,   9'd151, 9'd200};
         {3'd1,3'd4}: b = '{17'd1505,  17'd2504,   9'd201, 9'd300};
         {3'd1,3'd5}: b = '{17'd2505,  17'd5004,   9'd301, 9'd500};
         {3'd2,3'd0}: b = '{17'd0,     17'd350,    9'd0,   9'd50};
         {3'd2,3'd1}: b = '{17'd351,   17'd754,    9'd51,  9'd100};
         {3'd2,3'd2}: b = '{17'd755,   17'd1254,   9'd101, 9'd150};
         {3'd2,3'd3}: b = '{17'd1255,  17'd1754,   9'd151, 9'd200};
         {3'd2,3'd4}: b = '{17'd1755,  17'd2504,   9'd201, 9'd300};
         {3'd2,3'd5}: b = '{17'd2505,  17'd5004,   9'd301, 9'd500};
         {3'd3,3'd0}: b = '{17'd0,     17'd540,    9'd0,   9'd50};
         {3'd3,3'd1}: b = '{17'd550,   17'd1540,   9'd51,  9'd100};
         {3'd3,3'd2}: b = '{17'd1550,  17'd2540,   9'd101, 9'd150};
         {3'd3,3'd3}: b = '{17'd2550,  17'd3540,   9'd151, 9'd200};
         {3'd3,3'd4}: b = '{17'd3550,  17'd4240,   9'd201, 9'd300};
         {3'd3,3'd5}: b = '{17'd4250,  17'd6040,   9'd301, 9'd500};
         {3'd4,3'd0}: b = '{17'd0,     17'd3000,   9'd0,   9'd50};
         {3'd4,3'd1}: b = '{17'd3000,  17'd5000,   9'd51,  9'd100};
         {3'd4,3'd2}: b = '{17'd5000,  17'd10000,  9'd101, 9'd150};
         {3'd4,3'd3}: b = '{17'd10000, 17'd30000,  9'd151, 9'd200};
         {3'd4,3'd4}: b = '{17'd40000, 17'd50000,  9'd201, 9'd300};
         {3'd4,3'd5}: b = '{17'd50000, 17'd100000, 9'd301, 9'd500};
         default:     b = '0;
      endcase
      return b;
   endfunction

endpackage

// File: rtl/aqi_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
module aqi_div_pipe #(
   parameter int NumW = 28,
   parameter int DenW = 20
) (
   input  logic            clock,
   input  logic            en,
   input  logic [NumW-1:0] num,
   input  logic [DenW-1:0] den,
   output logic [NumW-1:0] quo
);
   for (genvar s = 0; s < NumW; s++) begin : g_stage
      logic [NumW-1:0] q_ff;
      logic [NumW-1:0] q_cur;
      logic [DenW-1:0] rem_cur;
      logic [DenW-1:0] d_cur;
      logic [DenW:0]   sh;
      logic [DenW+1:0] trial;

      if (s == 0) begin : g_head
         assign q_cur   = num;
         assign rem_cur = '0;
         assign d_cur   = den;
      end else begin : g_body
         assign q_cur   = g_stage[s-1].q_ff;
         assign rem_cur = g_stage[s-1].g_carry.rem_ff;
         assign d_cur   = g_stage[s-1].g_carry.d_ff;
      end

      assign sh    = {rem_cur, q_cur[NumW-1]};
      assign trial = {1'b0, sh} - {2'b0, d_cur};

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff <= {q_cur[NumW-2:0], !trial[DenW+1]};
         end
      end

      // the last stage only needs its quotient bit
      if (s < NumW - 1) begin : g_carry
         logic [DenW-1:0] rem_ff;
         logic [DenW-1:0] d_ff;
         always_ff @(posedge clock) begin
            if (en) begin
               d_ff <= d_cur;
               if (!trial[DenW+1]) begin
                  rem_ff <= trial[DenW-1:0];
               end else begin
                  rem_ff <= sh[DenW-1:0];
               end
            end
         end
      end
   end

   assign quo = g_stage[NumW-1].q_ff;
endmodule

// File: rtl/aqi_lane.sv
// One pollutant: average, band pick, interpolate, round.
module aqi_lane #(
   parameter int Bands = aqi_pkg::DefBands,
   parameter logic [2:0] Poll = 3'd0
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [aqi_pkg::SumW-1:0]   sum,
   input  logic [aqi_pkg::CntW-1:0]   cnt,
   output logic [aqi_pkg::IdxW-1:0]   idx
);
   localparam int NB = (Bands < 1) ? 1 :
                       ((Bands > aqi_pkg::TableRows) ? aqi_pkg::TableRows : Bands);
   localparam int AW = aqi_pkg::AvgW;
   localparam int RndW = 44;

   logic [AW-1:0] avg;
   logic [aqi_pkg::CntW-1:0] cnt_c;
   assign cnt_c = (cnt == '0) ? aqi_pkg::CntW'(1) : cnt;

   aqi_div_pipe #(.NumW(AW), .DenW(aqi_pkg::CntW)) u_avg (
      .clock(clock), .en(en), .num({sum, 4'b0}), .den(cnt_c), .quo(avg)
   );

   // band choice: first row whose upper bound covers avg
   aqi_pkg::band_type sel;
   always_comb begin
      aqi_pkg::band_type row;
      sel = aqi_pkg::bp_row(Poll, 3'(NB-1));
      for (int i = NB-1; i >= 0; i--) begin
         row = aqi_pkg::bp_row(Poll, 3'(i));
         if ({3'b0, avg} <= {10'b0, row.cp_hi, 4'b0})
            sel = row;
      end
   end

   logic [AW-1:0]   avg_ff;
   aqi_pkg::band_type b_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         avg_ff <= avg;
         b_ff   <= sel;
      end
   end

   // t = ilo*den + di*(avg-lo); den=16*(hi-lo) < 2^21
   logic signed [29:0] dx;
   logic [20:0] den;
   logic [8:0]  di;
   assign dx  = $signed({2'b0, avg_ff}) - $signed({9'b0, b_ff.cp_lo, 4'b0});
   assign den = {b_ff.cp_hi - b_ff.cp_lo, 4'b0};
   assign di  = b_ff.ip_hi - b_ff.ip_lo;

   logic signed [40:0] prod_ff;
   logic [29:0] base_ff;
   logic [20:0] den_ff;
   logic [8:0]  ilo_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= 41'(dx) * $signed({32'b0, di});
         base_ff <= {21'b0, b_ff.ip_lo} * {9'b0, den};
         den_ff  <= den;
         ilo_ff  <= b_ff.ip_lo;
      end
   end

   logic signed [41:0] t;
   logic        neg;
   logic [41:0] mag;
   assign t   = 42'(prod_ff) + $signed({12'b0, base_ff});
   assign neg = t[41];
   assign mag = neg ? 42'(-t) : t;

   // (2|t| + den) / (2 den), magnitude < 2^43
   logic [RndW-1:0] rq;
   aqi_div_pipe #(.NumW(RndW), .DenW(22)) u_rnd (
      .clock(clock), .en(en),
      .num({1'b0, mag, 1'b0} + {23'b0, den_ff}),
      .den({den_ff, 1'b0}),
      .quo(rq)
   );

   // carry empty-band flag, sign and low index alongside the divider
   logic [10:0] side_ff [RndW];
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= {den_ff == '0, neg, ilo_ff};
         for (int k = 1; k < RndW; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   logic [10:0] side;
   assign side = side_ff[RndW-1];

   always_comb begin
      if (side[10])                         idx = {4'b0, side[8:0]};
      else if (side[9] && rq != '0)         idx = '0;
      else if (rq > RndW'(aqi_pkg::IndexMax)) idx = aqi_pkg::IndexMax;
      else                                  idx = rq[aqi_pkg::IdxW-1:0];
   end
endmodule

// File: rtl/aqi_merge.sv
// Register the lanes' results with their maximum.
module aqi_merge (
   input  logic                      clock,
   input  logic                      en,
   input  aqi_pkg::subs_type         subs,
   output aqi_pkg::subs_type         subs_ff,
   output logic [aqi_pkg::IdxW-1:0]  max_ff
);
   logic [aqi_pkg::IdxW-1:0] m0, m1, m2;
   assign m0 = (subs.pm1 > subs.pm25) ? subs.pm1 : subs.pm25;
   assign m1 = (subs.pm4 > subs.pm10) ? subs.pm4 : subs.pm10;
   assign m2 = (m0 > m1) ? m0 : m1;
   always_ff @(posedge clock) begin
      if (en) begin
         subs_ff <= subs;
         max_ff  <= (m2 > subs.tvoc) ? m2 : subs.tvoc;
      end
   end
endmodule

// File: rtl/air_quality_index_calc_top.sv
// Air quality index calculator. Five lanes average each sum over sample_count
// (0 counts as 1) and map it through a six-band breakpoint table; a merge stage
// adds the maximum. One item is accepted per clock while the pipeline is not stalled;
// the stages are a 28-stage averaging divider, two table/multiply stages, a 44-stage rounding
// divider and the merge. The pipeline advances only while the output stage can move;
// a stall on rsp_tready stalls the whole pipeline.
module air_quality_index_calc_top #(
   parameter int Bands = aqi_pkg::DefBands
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // pm1_sum, pm25_sum, pm4_sum, pm10_sum, tvoc_sum, sample_count
   input  logic [127:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // pm1, pm25, pm4, pm10, tvoc, overall index; zero padded to 80 bits
   output logic [79:0]   rsp_tdata
);
   localparam int Lat = aqi_pkg::AvgW + 2 + 44 + 1;

   logic en;
   logic [Lat-1:0] v_ff;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v_ff[Lat-1];

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (en) v_ff <= {v_ff[Lat-2:0], req_tvalid};
   end

   logic [aqi_pkg::CntW-1:0] cnt;
   assign cnt  = req_tdata[127:120];

   logic [aqi_pkg::IdxW-1:0] lidx [aqi_pkg::NumPoll];
   for (genvar p = 0; p < aqi_pkg::NumPoll; p++) begin : g_lane
      aqi_lane #(.Bands(Bands), .Poll(3'(p))) u_lane (
         .clock(clock), .en(en),
         .sum(req_tdata[p*aqi_pkg::SumW +: aqi_pkg::SumW]), .cnt(cnt), .idx(lidx[p])
      );
   end

   aqi_pkg::subs_type subs, subs_ff;
   logic [aqi_pkg::IdxW-1:0] max_ff;
   assign subs = '{lidx[4], lidx[3], lidx[2], lidx[1], lidx[0]};

   aqi_merge u_merge (.clock(clock), .en(en), .subs(subs), .subs_ff(subs_ff),
                      .max_ff(max_ff));

   assign rsp_tdata = {2'b0, max_ff, subs_ff};

   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready) else $error("ready while stalled");
   a_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[77:65] >= rsp_tdata[12:0]) else $error("max below pm1");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
endmodule

// File: verif/tb_air_quality_index_calc_top.sv
module tb_air_quality_index_calc_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Latency = 75;
   localparam int WatchLimit = 20000;
   localparam int NumPoll = aqi_pkg::NumPoll;
   localparam int TableRows = aqi_pkg::TableRows;
   localparam int SumW = aqi_pkg::SumW;
   localparam int CntW = aqi_pkg::CntW;
   localparam int IdxW = aqi_pkg::IdxW;

   typedef struct {
      logic [IdxW-1:0] sub[NumPoll];
      logic [IdxW-1:0] overall;
   } aqi_result_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   // pm1_sum, pm25_sum, pm4_sum, pm10_sum, tvoc_sum, sample_count
   logic [127:0]  req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   // pm1, pm25, pm4, pm10, tvoc, overall index
   logic [79:0]   rsp_tdata;

   aqi_result_type pending_indexes[$];
   int            error_count;
   int            items_sent;
   int            results_seen;
   int            idle_cycles;
   int            stall_left;
   bit            calm_mode;

   air_quality_index_calc_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // breakpoint rows {cp_lo, cp_hi, ip_lo, ip_hi}, concentrations in 0.1 units
   function automatic void band_limits(input int p, input int r, output longint cp_lo,
                                       output longint cp_hi, output longint ip_lo,
                                       output longint ip_hi);
      longint tab[NumPoll][TableRows][4];
      tab = '{
         '{'{0, 80, 0, 50}, '{81, 254, 51, 100}, '{255, 354, 101, 150},
           '{355, 504, 151, 200}, '{505, 754, 201, 300}, '{755, 5004, 301, 500}},
         '{'{0, 120, 0, 50}, '{121, 354, 51, 100}, '{355, 554, 101, 150},
           '{555, 1504, 151, 200}, '{1505, 2504, 201, 300}, '{2505, 5004, 301, 500}},
         '{'{0, 350, 0, 50}, '{351, 754, 51, 100}, '{755, 1254, 101, 150},
           '{1255, 1754, 151, 200}, '{1755, 2504, 201, 300}, '{2505, 5004, 301, 500}},
         '{'{0, 540, 0, 50}, '{550, 1540, 51, 100}, '{1550, 2540, 101, 150},
           '{2550, 3540, 151, 200}, '{3550, 4240, 201, 300}, '{4250, 6040, 301, 500}},
         '{'{0, 3000, 0, 50}, '{3000, 5000, 51, 100}, '{5000, 10000, 101, 150},
           '{10000, 30000, 151, 200}, '{40000, 50000, 201, 300},
           '{50000, 100000, 301, 500}}
      };
      cp_lo = tab[p][r][0];
      cp_hi = tab[p][r][1];
      ip_lo = tab[p][r][2];
      ip_hi = tab[p][r][3];
   endfunction

   function automatic logic [IdxW-1:0] lane_index(input int p, input longint avg);
      int     sel;
      longint cp_lo, cp_hi, ip_lo, ip_hi, lo, den, t, r;
      sel = TableRows - 1;
      // first band whose top reaches the average; gaps fall into the next band
      for (int i = TableRows - 1; i >= 0; i--) begin
         band_limits(p, i, cp_lo, cp_hi, ip_lo, ip_hi);
         if (avg <= cp_hi * 16) sel = i;
      end
      band_limits(p, sel, cp_lo, cp_hi, ip_lo, ip_hi);
      lo = cp_lo * 16;
      den = cp_hi * 16 - lo;
      if (den <= 0) begin
         r = ip_lo;
      end else begin
         t = ip_lo * den + (ip_hi - ip_lo) * (avg - lo);
         if (t >= 0) r = (2 * t + den) / (2 * den);
         else r = -((-2 * t + den) / (2 * den));
      end
      if (r < 0) r = 0;
      if (r > 8191) r = 8191;
      return IdxW'(r);
   endfunction

   function automatic aqi_result_type predict_indexes(input logic [127:0] data);
      aqi_result_type res;
      longint      cnt, sum;
      cnt = data[5*SumW +: CntW];
      if (cnt == 0) cnt = 1;
      res.overall = '0;
      for (int p = 0; p < NumPoll; p++) begin
         sum = data[p*SumW +: SumW];
         res.sub[p] = lane_index(p, (sum * 16) / cnt);
         if (res.sub[p] > res.overall) res.overall = res.sub[p];
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("mismatch on result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
   endtask

   task automatic send_reading(input logic [SumW-1:0] sums[NumPoll],
                               input logic [CntW-1:0] count);
      logic [127:0] data;
      int           gap;
      data = '0;
      for (int p = 0; p < NumPoll; p++) data[p*SumW +: SumW] = sums[p];
      data[5*SumW +: CntW] = count;
      if (!calm_mode && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_indexes.push_back(predict_indexes(data));
      items_sent++;
   endtask

   task automatic finish_stream();
      req_tvalid <= 1'b0;
   endtask

   // random sum biased to land near band edges for a random count
   function automatic logic [SumW-1:0] pick_sum(input int p, input int cnt);
      longint cp_lo, cp_hi, ip_lo, ip_hi, v;
      case ($urandom_range(0, 3))
         0: v = $urandom_range(0, 24'hFFFFFF);
         1: v = $urandom_range(0, 1200) * (cnt == 0 ? 1 : cnt);
         default: begin
            band_limits(p, $urandom_range(0, TableRows - 1), cp_lo, cp_hi, ip_lo, ip_hi);
            v = (($urandom_range(0, 1) ? cp_hi : cp_lo) * (cnt == 0 ? 1 : cnt))
                + longint'(int'($urandom_range(0, 4))) - 2;
         end
      endcase
      if (v < 0) v = 0;
      if (v > 24'hFFFFFF) v = 24'hFFFFFF;
      return SumW'(v);
   endfunction

   task automatic test_directed();
      logic [SumW-1:0] s[NumPoll];
      longint          cp_lo, cp_hi, ip_lo, ip_hi;
      // all zero, zero count, all ones, minimal sums, alternating bit patterns
      s = '{default: '0};          send_reading(s, 8'd0);
      s = '{default: 24'hFFFFFF};  send_reading(s, 8'd0);
      s = '{default: 24'hFFFFFF};  send_reading(s, 8'd255);
      s = '{default: 24'h000001};  send_reading(s, 8'd255);
      s = '{default: 24'hAAAAAA};  send_reading(s, 8'hAA);
      s = '{default: 24'h555555};  send_reading(s, 8'h55);
      // each band's upper edge and the value just above it, count of one
      for (int r = 0; r < TableRows; r++) begin
         for (int p = 0; p < NumPoll; p++) begin
            band_limits(p, r, cp_lo, cp_hi, ip_lo, ip_hi);
            s[p] = SumW'(cp_hi);
         end
         send_reading(s, 8'd1);
         for (int p = 0; p < NumPoll; p++) s[p] = s[p] + 1;
         send_reading(s, 8'd1);
      end
      // fractional averages for rounding
      s = '{24'd2403, 24'd3625, 24'd1001, 24'd5443, 24'd29999};
      send_reading(s, 8'd7);
   endtask

   task automatic test_random(input int n);
      logic [SumW-1:0] s[NumPoll];
      int              cnt;
      for (int k = 0; k < n; k++) begin
         cnt = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 16);
         for (int p = 0; p < NumPoll; p++) s[p] = pick_sum(p, cnt);
         send_reading(s, CntW'(cnt));
      end
   endtask

   // sink side: random stall bursts, compare each item against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (calm_mode) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 5);
         end else begin
            rsp_tready <= 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            aqi_result_type want;
            if (pending_indexes.size() == 0) begin
               error_count++;
               $display("result with no pending prediction");
            end else begin
               want = pending_indexes.pop_front();
               for (int p = 0; p < NumPoll; p++)
                  if (rsp_tdata[p*IdxW +: IdxW] !== want.sub[p])
                     report_mismatch($sformatf("lane %0d", p),
                                     rsp_tdata[p*IdxW +: IdxW], want.sub[p]);
               if (rsp_tdata[5*IdxW +: IdxW] !== want.overall)
                  report_mismatch("overall", rsp_tdata[5*IdxW +: IdxW], want.overall);
            end
            results_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("tb_air_quality_index_calc_top: FAIL");
         $finish;
      end
   end

   initial begin
      error_count  = 0;
      items_sent   = 0;
      results_seen = 0;
      idle_cycles  = 0;
      calm_mode    = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1300);
      calm_mode = 1'b1;
      test_random(200);
      finish_stream();
      while (pending_indexes.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
      $display("covered %0d readings: band edges, gaps, zero count, saturation, random",
               items_sent);
      $display("checked %0d index results", results_seen);
      if (error_count == 0) $display("tb_air_quality_index_calc_top: PASS");
      else $display("tb_air_quality_index_calc_top: FAIL");
      $finish;
   end

endmodule
